// ===== rtl/ttup_pkg.sv =====
// Package for the text to unsigned parser: parse phases, character codes,
// radix constants and the digit decode function.
// Depends on nothing; the core, the result register and the top level refer to it.
`default_nettype none

package ttup_pkg;

   // Phases of the parse of one string.
   typedef enum logic [2:0] {
      PH_SPACE  = 3'd0,
      PH_SIGNED = 3'd1,
      PH_ZERO   = 3'd2,
      PH_DIGITS = 3'd3,
      PH_DONE   = 3'd4
   } phase_type;

   // Status flags that travel with a result word.
   typedef struct packed {
      logic overflowed;
      logic digits_found;
   } rsp_flags_type;

   localparam int BASE_WIDTH  = 6;
   localparam int DIGIT_WIDTH = BASE_WIDTH + 1;

   localparam logic [BASE_WIDTH-1:0] BASE_AUTO  = 6'd0;
   localparam logic [BASE_WIDTH-1:0] BASE_UNARY = 6'd1;
   localparam logic [BASE_WIDTH-1:0] BASE_OCT   = 6'd8;
   localparam logic [BASE_WIDTH-1:0] BASE_DEC   = 6'd10;
   localparam logic [BASE_WIDTH-1:0] BASE_HEX   = 6'd16;
   localparam logic [BASE_WIDTH-1:0] BASE_MAX   = 6'd36;

   localparam logic [DIGIT_WIDTH-1:0] NOT_A_DIGIT = 7'd64;

   localparam logic [7:0] CHAR_SPACE   = 8'h20;
   localparam logic [7:0] CHAR_TAB     = 8'h09;
   localparam logic [7:0] CHAR_CR      = 8'h0D;
   localparam logic [7:0] CHAR_LF      = 8'h0A;
   localparam logic [7:0] CHAR_PLUS    = 8'h2B;
   localparam logic [7:0] CHAR_MINUS   = 8'h2D;
   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CHAR_NINE    = 8'h39;
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
   localparam logic [7:0] CHAR_UPPER_X = 8'h58;
   localparam logic [7:0] CHAR_LOWER_X = 8'h78;
   localparam logic [7:0] UPPER_OFFSET = 8'd55;
   localparam logic [7:0] LOWER_OFFSET = 8'd87;

   // Value of a digit or letter (letters count from ten), else NOT_A_DIGIT.
   function automatic logic [DIGIT_WIDTH-1:0] digit_value(input logic [7:0] c);
      logic [7:0] diff;
      begin
         diff = 8'd0;
         digit_value = NOT_A_DIGIT;
         if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
            diff = c - CHAR_ZERO;
            digit_value = diff[DIGIT_WIDTH-1:0];
         end else if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
            diff = c - UPPER_OFFSET;
            digit_value = diff[DIGIT_WIDTH-1:0];
         end else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) begin
            diff = c - LOWER_OFFSET;
            digit_value = diff[DIGIT_WIDTH-1:0];
         end
      end
   endfunction

endpackage

`default_nettype wire

// ===== rtl/ttup_req_if.sv =====
// Request channel of the text parser: one text byte and its end marker.
// Depends on nothing.
`default_nettype none

interface ttup_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_byte;
   logic       last_byte;

   modport source (output valid, output char_byte, output last_byte, input ready);
   modport sink   (input valid, input char_byte, input last_byte, output ready);
endinterface

`default_nettype wire

// ===== rtl/ttup_rsp_if.sv =====
// Response channel of the text parser: the parsed value and its status.
// Depends on nothing; widths follow the interface parameters.
`default_nettype none

interface ttup_rsp_if #(
   parameter int VALUE_WIDTH = 64,
   parameter int COUNT_WIDTH = 16
);
   logic                   valid;
   logic                   ready;
   logic [VALUE_WIDTH-1:0] parsed_value;
   logic                   overflowed;
   logic                   digits_found;
   logic [COUNT_WIDTH-1:0] consumed_count;

   modport source (output valid, output parsed_value, output overflowed,
                   output digits_found, output consumed_count, input ready);
   modport sink   (input valid, input parsed_value, input overflowed,
                   input digits_found, input consumed_count, output ready);
endinterface

`default_nettype wire

// ===== rtl/ttup_in_stage.sv =====
// Input register of the text parser: holds one request word for the core.
// Depends on nothing else of the block.
`default_nettype none

module ttup_in_stage (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [7:0] req_char,
   input  wire logic       req_last,
   input  wire logic       advance,
   output logic            hold_valid,
   output logic [7:0]      hold_char,
   output logic            hold_last
);

   logic       valid_ff, valid_in;
   logic [7:0] char_ff;
   logic       last_ff;

   // Space is free when empty or when the held word moves on this cycle.
   assign req_ready = !valid_ff || advance;

   always_comb begin
      valid_in = valid_ff;
      if (req_valid && req_ready) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Payload needs no reset.
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         char_ff <= req_char;
         last_ff <= req_last;
      end
   end

   assign hold_valid = valid_ff;
   assign hold_char  = char_ff;
   assign hold_last  = last_ff;

endmodule

`default_nettype wire

// ===== rtl/ttup_core.sv =====
// Parse core: per-string state, base register and the combinational step logic.
// Depends on ttup_pkg for phases, character codes and the digit decode.
`default_nettype none

module ttup_core #(
   parameter int VALUE_WIDTH = 64,
   parameter int COUNT_WIDTH = 16
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 csr_we,
   input  wire logic [ttup_pkg::BASE_WIDTH-1:0]      csr_wdata,
   input  wire logic                                 in_valid,
   input  wire logic [7:0]                           in_char,
   input  wire logic                                 in_last,
   input  wire logic                                 out_free,
   output logic                                      in_advance,
   output logic                                      res_load,
   output logic [VALUE_WIDTH-1:0]                    res_value,
   output ttup_pkg::rsp_flags_type                   res_flags,
   output logic [COUNT_WIDTH-1:0]                    res_count
);

   localparam int BW        = ttup_pkg::BASE_WIDTH;
   localparam int DW        = ttup_pkg::DIGIT_WIDTH;
   localparam int ProdWidth = VALUE_WIDTH + BW;
   localparam int SumWidth  = VALUE_WIDTH + BW + 1;

   ttup_pkg::phase_type    phase_ff, phase_in;
   logic [VALUE_WIDTH-1:0] acc_ff, acc_in;
   logic                   neg_ff, neg_in;
   logic                   ovf_ff, ovf_in;
   logic                   any_ff, any_in;
   logic [BW-1:0]          base_ff, base_in;
   logic [COUNT_WIDTH-1:0] pos_ff, pos_in;
   logic [COUNT_WIDTH-1:0] end_ff, end_in;
   logic [BW-1:0]          cfg_base_ff;

   logic [DW-1:0]          dval;
   logic [BW-1:0]          base_use;
   logic                   try_digit, digit_ok, zero_mark, neg_mark, start;
   logic                   cfg_invalid, is_space;
   logic [ProdWidth-1:0]   prod;
   logic [SumWidth-1:0]    sum;
   logic                   carry;
   logic [VALUE_WIDTH-1:0] acc_neg;

   // A word moves on unless it ends a string and the result slot is busy.
   assign in_advance = in_valid && (!in_last || out_free);
   assign res_load   = in_advance && in_last;

   assign dval        = ttup_pkg::digit_value(in_char);
   assign cfg_invalid = (cfg_base_ff == ttup_pkg::BASE_UNARY) ||
                        (cfg_base_ff > ttup_pkg::BASE_MAX);
   assign is_space    = (in_char == ttup_pkg::CHAR_SPACE) || (in_char == ttup_pkg::CHAR_TAB) ||
                        (in_char == ttup_pkg::CHAR_CR) || (in_char == ttup_pkg::CHAR_LF);

   // Next phase and the controls of the datapath.
   always_comb begin
      phase_in  = phase_ff;
      base_use  = base_ff;
      base_in   = base_ff;
      try_digit = 1'b0;
      zero_mark = 1'b0;
      neg_mark  = 1'b0;
      start     = 1'b0;
      digit_ok  = 1'b0;
      unique case (phase_ff)
         ttup_pkg::PH_SPACE: begin
            if (is_space) begin
               phase_in = ttup_pkg::PH_SPACE;
            end else if (in_char == ttup_pkg::CHAR_MINUS) begin
               neg_mark = 1'b1;
               phase_in = ttup_pkg::PH_SIGNED;
            end else if (in_char == ttup_pkg::CHAR_PLUS) begin
               phase_in = ttup_pkg::PH_SIGNED;
            end else begin
               start = 1'b1;
            end
         end
         ttup_pkg::PH_SIGNED: begin
            start = 1'b1;
         end
         ttup_pkg::PH_ZERO: begin
            phase_in = ttup_pkg::PH_DIGITS;
            if (in_char == ttup_pkg::CHAR_LOWER_X || in_char == ttup_pkg::CHAR_UPPER_X) begin
               base_in = ttup_pkg::BASE_HEX;
            end else begin
               base_use  = (base_ff == ttup_pkg::BASE_AUTO) ? ttup_pkg::BASE_OCT : base_ff;
               base_in   = base_use;
               try_digit = 1'b1;
            end
         end
         ttup_pkg::PH_DIGITS: begin
            try_digit = 1'b1;
         end
         default: begin
            phase_in = ttup_pkg::PH_DONE;
         end
      endcase

      // First byte of the number samples the configured base.
      if (start) begin
         if (cfg_invalid) begin
            phase_in = ttup_pkg::PH_DONE;
         end else if (in_char == ttup_pkg::CHAR_ZERO &&
                      (cfg_base_ff == ttup_pkg::BASE_AUTO ||
                       cfg_base_ff == ttup_pkg::BASE_HEX)) begin
            zero_mark = 1'b1;
            base_in   = cfg_base_ff;
            phase_in  = ttup_pkg::PH_ZERO;
         end else begin
            base_use  = (cfg_base_ff == ttup_pkg::BASE_AUTO) ? ttup_pkg::BASE_DEC : cfg_base_ff;
            base_in   = base_use;
            phase_in  = ttup_pkg::PH_DIGITS;
            try_digit = 1'b1;
         end
      end

      // A byte that is no digit of the base ends the number.
      if (try_digit) begin
         digit_ok = dval < {1'b0, base_use};
         if (!digit_ok) begin
            phase_in = ttup_pkg::PH_DONE;
         end
      end
   end

   // Multiply-add by the base; any bit above the value width is overflow.
   assign prod  = ProdWidth'(acc_ff) * ProdWidth'(base_use);
   assign sum   = SumWidth'(prod) + SumWidth'(dval);
   assign carry = |sum[SumWidth-1:VALUE_WIDTH];

   // Datapath next values.
   always_comb begin
      acc_in = acc_ff;
      neg_in = neg_ff || neg_mark;
      ovf_in = ovf_ff;
      any_in = any_ff;
      end_in = end_ff;
      pos_in = (pos_ff == {COUNT_WIDTH{1'b1}}) ? pos_ff : pos_ff + COUNT_WIDTH'(1);
      if (zero_mark) begin
         any_in = 1'b1;
         end_in = pos_in;
      end
      if (digit_ok) begin
         any_in = 1'b1;
         end_in = pos_in;
         if (ovf_ff || carry) begin
            ovf_in = 1'b1;
         end else begin
            acc_in = sum[VALUE_WIDTH-1:0];
         end
      end
   end

   // Result word, formed from the state after this byte.
   assign acc_neg   = ~acc_in + VALUE_WIDTH'(1);
   assign res_value = ovf_in ? {VALUE_WIDTH{1'b1}} : (neg_in ? acc_neg : acc_in);
   assign res_flags.overflowed   = ovf_in;
   assign res_flags.digits_found = any_in;
   assign res_count = any_in ? end_in : {COUNT_WIDTH{1'b0}};

   // Per-string state; the end of a string returns it to reset values.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= ttup_pkg::PH_SPACE;
         acc_ff   <= '0;
         neg_ff   <= 1'b0;
         ovf_ff   <= 1'b0;
         any_ff   <= 1'b0;
         base_ff  <= '0;
         pos_ff   <= '0;
         end_ff   <= '0;
      end else if (in_advance) begin
         if (in_last) begin
            phase_ff <= ttup_pkg::PH_SPACE;
            acc_ff   <= '0;
            neg_ff   <= 1'b0;
            ovf_ff   <= 1'b0;
            any_ff   <= 1'b0;
            base_ff  <= '0;
            pos_ff   <= '0;
            end_ff   <= '0;
         end else begin
            phase_ff <= phase_in;
            acc_ff   <= acc_in;
            neg_ff   <= neg_in;
            ovf_ff   <= ovf_in;
            any_ff   <= any_in;
            base_ff  <= base_in;
            pos_ff   <= pos_in;
            end_ff   <= end_in;
         end
      end
   end

   // Base register, written from the control port.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_base_ff <= '0;
      end else if (csr_we) begin
         cfg_base_ff <= csr_wdata;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/ttup_out_stage.sv =====
// Result register of the text parser: holds one response word until taken.
// Depends on ttup_pkg for the status flag struct.
`default_nettype none

module ttup_out_stage #(
   parameter int VALUE_WIDTH = 64,
   parameter int COUNT_WIDTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     load,
   input  wire logic [VALUE_WIDTH-1:0]   load_value,
   input  wire ttup_pkg::rsp_flags_type  load_flags,
   input  wire logic [COUNT_WIDTH-1:0]   load_count,
   output logic                          free,
   output logic                          rsp_valid,
   input  wire logic                     rsp_ready,
   output logic [VALUE_WIDTH-1:0]        rsp_value,
   output ttup_pkg::rsp_flags_type       rsp_flags,
   output logic [COUNT_WIDTH-1:0]        rsp_count
);

   logic                    valid_ff, valid_in;
   logic [VALUE_WIDTH-1:0]  value_ff;
   ttup_pkg::rsp_flags_type flags_ff;
   logic [COUNT_WIDTH-1:0]  count_ff;

   // The slot takes a new word when empty or when its word leaves now.
   assign free = !valid_ff || rsp_ready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         value_ff <= load_value;
         flags_ff <= load_flags;
         count_ff <= load_count;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_value = value_ff;
   assign rsp_flags = flags_ff;
   assign rsp_count = count_ff;

endmodule

`default_nettype wire

// ===== rtl/text_to_unsigned_parser_unit.sv =====
// Text to unsigned parser, top level.
// A string arrives on req_if one byte per word, the final byte flagged by
// last_byte. Leading blanks, one sign and a 0x prefix are handled, then
// digits of the configured base (csr_wdata written with csr_we; zero picks
// octal, decimal or hex from the text) are accumulated. One word leaves on
// rsp_if for each final byte: the value (negated after a minus, all ones on
// overflow), the overflow and digits-found flags and the consumed length.
// Throughput is one byte per cycle while a final byte does not wait for the
// result register: each byte takes one multiply-add by the base of at most
// six bits in the step logic between the input register and the result
// register. The result word of a final byte is loaded from the step logic
// into the result register when that register is free, then shows on rsp_if.
// While rsp_if stalls, bytes that are not final are still taken; a further
// final byte waits in the input register and req_if.ready falls.
// Synchronous reset empties both registers, clears the string state and
// sets the base register to automatic detection.
// Depends on ttup_pkg, the two channel interfaces and the three stages.
`default_nettype none

module text_to_unsigned_parser_unit #(
   parameter int VALUE_WIDTH = 64,
   parameter int COUNT_WIDTH = 16
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   ttup_req_if.sink                                  req_if,
   ttup_rsp_if.source                                rsp_if,
   input  wire logic                                 csr_we,
   input  wire logic [ttup_pkg::BASE_WIDTH-1:0]      csr_wdata
);

   logic                    hold_valid, hold_last, advance, out_free, res_load;
   logic [7:0]              hold_char;
   logic [VALUE_WIDTH-1:0]  res_value;
   ttup_pkg::rsp_flags_type res_flags, out_flags;
   logic [COUNT_WIDTH-1:0]  res_count;

   // Input register.
   ttup_in_stage u_in (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_if.valid),
      .req_ready  (req_if.ready),
      .req_char   (req_if.char_byte),
      .req_last   (req_if.last_byte),
      .advance    (advance),
      .hold_valid (hold_valid),
      .hold_char  (hold_char),
      .hold_last  (hold_last)
   );

   // Step logic and string state.
   ttup_core #(
      .VALUE_WIDTH (VALUE_WIDTH),
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .in_valid   (hold_valid),
      .in_char    (hold_char),
      .in_last    (hold_last),
      .out_free   (out_free),
      .in_advance (advance),
      .res_load   (res_load),
      .res_value  (res_value),
      .res_flags  (res_flags),
      .res_count  (res_count)
   );

   // Result register.
   ttup_out_stage #(
      .VALUE_WIDTH (VALUE_WIDTH),
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_out (
      .clock      (clock),
      .reset      (reset),
      .load       (res_load),
      .load_value (res_value),
      .load_flags (res_flags),
      .load_count (res_count),
      .free       (out_free),
      .rsp_valid  (rsp_if.valid),
      .rsp_ready  (rsp_if.ready),
      .rsp_value  (rsp_if.parsed_value),
      .rsp_flags  (out_flags),
      .rsp_count  (rsp_if.consumed_count)
   );

   assign rsp_if.overflowed   = out_flags.overflowed;
   assign rsp_if.digits_found = out_flags.digits_found;

`ifndef SYNTHESIS
   // A word without digits carries a zero value and a zero length.
   assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && !rsp_if.digits_found |->
         rsp_if.parsed_value == '0 && rsp_if.consumed_count == '0 && !rsp_if.overflowed)
      else $error("result without digits is not all zero");

   // Overflow saturates the value to all ones.
   assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && rsp_if.overflowed |-> rsp_if.parsed_value == {VALUE_WIDTH{1'b1}})
      else $error("overflowed result is not saturated");

   // Input back-pressure only comes from a stalled result slot.
   assert property (@(posedge clock) disable iff (reset)
      !req_if.ready |-> rsp_if.valid && !rsp_if.ready && hold_last)
      else $error("request stalled without a blocked final byte");
`endif

endmodule

`default_nettype wire
